// ===== sv/c3r_pkg.sv =====
// shared types and constants for the 3x3 convolution layer with relu
package c3r_pkg;

    // command codes carried on the slave tuser
    typedef enum logic [1:0] {
        CMD_LOAD_WEIGHT = 2'd0,
        CMD_LOAD_BIAS   = 2'd1,
        CMD_LOAD_PIXEL  = 2'd2,
        CMD_COMPUTE     = 2'd3
    } cmd_code_t;

    // input beat layout
    localparam int CMD_W      = 2;
    localparam int WIDX_W     = 11;
    localparam int POS_W      = 4;
    localparam int CH_W       = 4;
    localparam int VAL_W      = 16;
    localparam int WIDX_LSB   = 0;
    localparam int ROW_LSB    = WIDX_LSB + WIDX_W;
    localparam int COL_LSB    = ROW_LSB + POS_W;
    localparam int CH_LSB     = COL_LSB + POS_W;
    localparam int VAL_LSB    = CH_LSB + CH_W;
    localparam int S_TDATA_W  = 40;

    // output beat layout
    localparam int OCH_W      = 4;
    localparam int ACT_W      = 15;
    localparam int M_PAD_W    = 5;
    localparam int M_TDATA_W  = OCH_W + ACT_W + M_PAD_W;

    // fixed point
    localparam int FRAC_BITS  = 10;
    localparam int PROD_W     = 2 * VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR_OUT,
        ST_OC_INIT,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_weight;
        logic wr_bias;
        logic wr_pixel;
        logic start;
        logic oc_init;
        logic acc_load;
        logic issue;
        logic next_oc;
        logic out_load;
        logic out_err;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pos_ok;
        logic last_step;
        logic last_oc;
        logic pipe_busy;
    } dp_sts_t;

endpackage

// ===== sv/c3r_ctrl.sv =====
// controller state machine: sequences loads, per-channel mac runs and result beats
module c3r_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  c3r_pkg::dp_sts_t   sts,
    output c3r_pkg::dp_cmd_t   cmd
);
    import c3r_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        valid_reg;
    logic        valid_next;
    logic        in_acc;
    logic        out_free;
    cmd_code_t   code;

    assign code          = cmd_code_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && code == CMD_COMPUTE)
                begin
                    state_next = sts.pos_ok ? ST_OC_INIT : ST_ERR_OUT;
                end
            end
            ST_ERR_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OC_INIT: state_next = ST_BIAS;
            ST_BIAS:    state_next = ST_MAC;
            ST_MAC:
            begin
                if (sts.last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = sts.last_oc ? ST_IDLE : ST_OC_INIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_weight = in_acc && (code == CMD_LOAD_WEIGHT);
                cmd.wr_bias   = in_acc && (code == CMD_LOAD_BIAS);
                cmd.wr_pixel  = in_acc && (code == CMD_LOAD_PIXEL);
                cmd.start     = in_acc && (code == CMD_COMPUTE);
            end
            ST_ERR_OUT:
            begin
                cmd.out_load = out_free;
                cmd.out_err  = 1'b1;
            end
            ST_OC_INIT: cmd.oc_init  = 1'b1;
            ST_BIAS:    cmd.acc_load = 1'b1;
            ST_MAC:     cmd.issue    = 1'b1;
            ST_DRAIN:   cmd          = '0;
            ST_EMIT:
            begin
                cmd.out_load = out_free;
                cmd.next_oc  = out_free && !sts.last_oc;
            end
            default:    cmd          = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== sv/c3r_dp.sv =====
// datapath: weight, bias and pixel stores, address walk, multiply-accumulate, result register
module c3r_dp
#(
    parameter int IN_SIZE      = 13,
    parameter int IN_CHANNELS  = 8,
    parameter int OUT_CHANNELS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [c3r_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  c3r_pkg::dp_cmd_t                cmd,
    output c3r_pkg::dp_sts_t                sts,
    output logic [c3r_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser
);
    import c3r_pkg::*;

    localparam int W_DEPTH  = 9 * IN_CHANNELS * OUT_CHANNELS;
    localparam int P_DEPTH  = IN_SIZE * IN_SIZE * IN_CHANNELS;
    localparam int WA_W     = $clog2(W_DEPTH);
    localparam int PA_W     = $clog2(P_DEPTH);
    localparam int OC_W     = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int IC_W     = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int MAX_POS  = IN_SIZE - 3;
    localparam int ROW_STEP = (IN_SIZE - 3) * IN_CHANNELS + 1;

    localparam logic [IC_W-1:0] IC_LAST = IC_W'(IN_CHANNELS - 1);
    localparam logic [OC_W-1:0] OC_LAST = OC_W'(OUT_CHANNELS - 1);

    logic [WIDX_W-1:0]       f_widx;
    logic [POS_W-1:0]        f_row;
    logic [POS_W-1:0]        f_col;
    logic [CH_W-1:0]         f_ch;
    logic [VAL_W-1:0]        f_value;

    logic                    w_in_range;
    logic                    b_in_range;
    logic                    p_in_range;
    logic [PA_W-1:0]         p_wr_addr;

    logic [VAL_W-1:0]        w_mem [W_DEPTH];
    logic [VAL_W-1:0]        b_mem [OUT_CHANNELS];
    logic [VAL_W-1:0]        p_mem [P_DEPTH];

    logic [PA_W-1:0]         base_reg;
    logic [PA_W-1:0]         pix_ptr_reg;
    logic [WA_W-1:0]         w_ptr_reg;
    logic [OC_W-1:0]         oc_reg;
    logic [IC_W-1:0]         ic_reg;
    logic [1:0]              kc_reg;
    logic [1:0]              kr_reg;

    logic signed [VAL_W-1:0] pix_q_reg;
    logic signed [VAL_W-1:0] wgt_q_reg;
    logic [VAL_W-1:0]        bias_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]        acc_reg;
    logic                    v1_reg;
    logic                    v2_reg;

    logic [OCH_W-1:0]        och_reg;
    logic [ACT_W-1:0]        act_reg;
    logic                    last_reg;
    logic                    err_reg;

    assign f_widx  = s_axis_tdata[WIDX_LSB +: WIDX_W];
    assign f_row   = s_axis_tdata[ROW_LSB +: POS_W];
    assign f_col   = s_axis_tdata[COL_LSB +: POS_W];
    assign f_ch    = s_axis_tdata[CH_LSB +: CH_W];
    assign f_value = s_axis_tdata[VAL_LSB +: VAL_W];

    assign w_in_range = 32'(f_widx) < W_DEPTH;
    assign b_in_range = 32'(f_ch) < OUT_CHANNELS;
    assign p_in_range = (32'(f_row) < IN_SIZE) && (32'(f_col) < IN_SIZE)
                        && (32'(f_ch) < IN_CHANNELS);
    assign p_wr_addr  = PA_W'((32'(f_row) * IN_SIZE + 32'(f_col)) * IN_CHANNELS
                              + 32'(f_ch));

    assign sts.pos_ok    = (32'(f_row) <= MAX_POS) && (32'(f_col) <= MAX_POS);
    assign sts.last_step = (kr_reg == 2'd2) && (kc_reg == 2'd2) && (ic_reg == IC_LAST);
    assign sts.last_oc   = (oc_reg == OC_LAST);
    assign sts.pipe_busy = v1_reg || v2_reg;

    // weight store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_weight && w_in_range)
        begin
            w_mem[WA_W'(f_widx)] <= f_value;
        end
        if (cmd.issue)
        begin
            wgt_q_reg <= w_mem[w_ptr_reg];
        end
    end

    // bias store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_bias && b_in_range)
        begin
            b_mem[OC_W'(f_ch)] <= f_value;
        end
        if (cmd.oc_init)
        begin
            bias_q_reg <= b_mem[oc_reg];
        end
    end

    // input map, ordered row, col, channel
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pixel && p_in_range)
        begin
            p_mem[p_wr_addr] <= f_value;
        end
        if (cmd.issue)
        begin
            pix_q_reg <= p_mem[pix_ptr_reg];
        end
    end

    // address walk over kernel taps and input channels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            pix_ptr_reg <= '0;
            w_ptr_reg   <= '0;
            oc_reg      <= '0;
            ic_reg      <= '0;
            kc_reg      <= '0;
            kr_reg      <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                base_reg <= PA_W'((32'(f_row) * IN_SIZE + 32'(f_col)) * IN_CHANNELS);
                oc_reg   <= '0;
            end
            else if (cmd.next_oc)
            begin
                oc_reg <= oc_reg + OC_W'(1);
            end

            if (cmd.oc_init)
            begin
                pix_ptr_reg <= base_reg;
                w_ptr_reg   <= WA_W'(oc_reg);
                ic_reg      <= '0;
                kc_reg      <= '0;
                kr_reg      <= '0;
            end
            else if (cmd.issue)
            begin
                w_ptr_reg <= w_ptr_reg + WA_W'(OUT_CHANNELS);
                if (ic_reg == IC_LAST)
                begin
                    ic_reg <= '0;
                    if (kc_reg == 2'd2)
                    begin
                        // jump back to the first column of the next kernel row
                        kc_reg      <= '0;
                        kr_reg      <= kr_reg + 2'd1;
                        pix_ptr_reg <= pix_ptr_reg + PA_W'(ROW_STEP);
                    end
                    else
                    begin
                        kc_reg      <= kc_reg + 2'd1;
                        pix_ptr_reg <= pix_ptr_reg + PA_W'(1);
                    end
                end
                else
                begin
                    ic_reg      <= ic_reg + IC_W'(1);
                    pix_ptr_reg <= pix_ptr_reg + PA_W'(1);
                end
            end
        end
    end

    // read -> multiply -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= pix_q_reg * wgt_q_reg;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= bias_q_reg;
        end
        else if (v2_reg)
        begin
            // floor to 10 fraction bits, wrap at 16 bits
            acc_reg <= acc_reg + prod_reg[FRAC_BITS +: VAL_W];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_err)
            begin
                och_reg  <= '0;
                act_reg  <= '0;
                last_reg <= 1'b1;
                err_reg  <= 1'b1;
            end
            else
            begin
                och_reg  <= OCH_W'(oc_reg);
                act_reg  <= acc_reg[VAL_W-1] ? '0 : acc_reg[ACT_W-1:0];
                last_reg <= sts.last_oc;
                err_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, act_reg, och_reg};
    assign m_axis_tlast = last_reg;
    assign m_axis_tuser = err_reg;

endmodule

// ===== sv/conv3x3_relu_layer_top.sv =====
// 3x3 valid convolution layer with bias and relu, 16-bit fixed point, 10 fraction bits
// loads are accepted back to back while idle
// a compute beat holds the input off until the beat of its last output channel is loaded,
// a hold-off set by the single shared multiplier; each result passes OC_INIT, BIAS, MAC,
// DRAIN and EMIT before it is loaded; an out-of-range compute has its single error beat
// loaded from ERR_OUT; output stalls add to both
// rst_n is asynchronous, active low, and clears control only; stores are undefined until written
module conv3x3_relu_layer_top
#(
    parameter int IN_SIZE      = 13,
    parameter int IN_CHANNELS  = 8,
    parameter int OUT_CHANNELS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream: commands and loads
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // weight_index[10:0], row[14:11], col[18:15], channel[22:19], value[38:23], zero[39]
    input  logic [c3r_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [c3r_pkg::CMD_W-1:0]       s_axis_tuser,
    // master stream: activations
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_channel[3:0], activation[18:4], zero[23:19]
    output logic [c3r_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    // error[0]
    output logic                            m_axis_tuser
);
    import c3r_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // the controller owns the handshakes and the result valid bit;
    // the datapath owns every store, pointer and the accumulator
    c3r_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    c3r_dp
    #(
        .IN_SIZE      (IN_SIZE),
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // an error beat is always the only, hence last, beat and carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("error beat without last or with nonzero data");

    // new commands are only taken with the mac pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.pipe_busy)
        else $error("input accepted while mac pipeline busy");

    // bias preload must not collide with a product still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_load |-> !sts.pipe_busy)
        else $error("accumulator preload during mac activity");

    // a result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten before the beat was taken");

endmodule

// ===== tb/sv/conv3x3_relu_layer_top_tb.sv =====
// self-checking testbench for the 3x3 convolution layer with relu, driven over its streams
module conv3x3_relu_layer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3r_pkg::*;

    // layer geometry, kept at the defaults of the block
    localparam int MAP_SIZE = 13;
    localparam int MAP_CH   = 8;
    localparam int OUT_CH   = 16;
    localparam int N_WGT    = 9 * MAP_CH * OUT_CH;
    localparam int N_PIX    = MAP_SIZE * MAP_SIZE * MAP_CH;
    localparam int LAST_POS = MAP_SIZE - 3;

    localparam int N_RANDOM     = 180;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 3000;
    // one full compute plus margin, so a stray beat after the last one is still seen
    localparam int DRAIN_CYCLES = 1300;
    localparam int REPORT_MAX   = 10;

    // one activation beat as seen on the master stream
    typedef struct packed {
        logic [OCH_W-1:0] och;
        logic [ACT_W-1:0] act;
        logic             last;
        logic             err;
    } act_beat_t;

    // where the expected beats of a directed row come from
    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_ERR_BEAT
    } exp_src_t;

    typedef struct packed {
        cmd_code_t   cmd;
        logic [10:0] widx;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [3:0]  ch;
        logic [15:0] val;
        exp_src_t    src;
    } dir_row_t;

    localparam act_beat_t ERR_BEAT = '{och: '0, act: '0, last: 1'b1, err: 1'b1};

    // directed rows: range errors, store corners, value extremes, ignored loads
    dir_row_t dir_rows [22] = '{
        // compute positions past the last valid one
        '{CMD_COMPUTE,     11'h7FF, 4'd11, 4'd0,  4'hF, 16'hFFFF, EXP_ERR_BEAT},
        '{CMD_COMPUTE,     11'h000, 4'd0,  4'd11, 4'h0, 16'h0000, EXP_ERR_BEAT},
        '{CMD_COMPUTE,     11'h7FF, 4'd15, 4'd15, 4'hF, 16'hFFFF, EXP_ERR_BEAT},
        // valid corners, with the unused fields at both extremes
        '{CMD_COMPUTE,     11'h000, 4'd10, 4'd10, 4'h0, 16'h0000, EXP_PREDICT},
        '{CMD_COMPUTE,     11'h7FF, 4'd0,  4'd0,  4'hF, 16'hFFFF, EXP_PREDICT},
        // first and last weight, then two weight addresses past the store
        '{CMD_LOAD_WEIGHT, 11'd0,    4'hF, 4'hF,  4'hF, 16'h7FFF, EXP_NONE},
        '{CMD_LOAD_WEIGHT, 11'd1151, 4'h0, 4'h0,  4'h0, 16'h8000, EXP_NONE},
        '{CMD_LOAD_WEIGHT, 11'd1152, 4'h0, 4'h0,  4'h0, 16'h1234, EXP_NONE},
        '{CMD_LOAD_WEIGHT, 11'h7FF,  4'h0, 4'h0,  4'h0, 16'h0000, EXP_NONE},
        // bias corners at both value extremes
        '{CMD_LOAD_BIAS,   11'h7FF, 4'hF, 4'hF,  4'd0,  16'h8000, EXP_NONE},
        '{CMD_LOAD_BIAS,   11'h000, 4'h0, 4'h0,  4'd15, 16'h7FFF, EXP_NONE},
        // pixel corners, then pixels off the map or past the channel count
        '{CMD_LOAD_PIXEL,  11'h7FF, 4'd0,  4'd0,  4'd0,  16'h7FFF, EXP_NONE},
        '{CMD_LOAD_PIXEL,  11'h000, 4'd12, 4'd12, 4'd7,  16'h8000, EXP_NONE},
        '{CMD_LOAD_PIXEL,  11'h000, 4'd13, 4'd0,  4'd0,  16'h5555, EXP_NONE},
        '{CMD_LOAD_PIXEL,  11'h000, 4'd0,  4'd13, 4'd0,  16'h5555, EXP_NONE},
        '{CMD_LOAD_PIXEL,  11'h000, 4'd0,  4'd0,  4'd8,  16'h5555, EXP_NONE},
        '{CMD_LOAD_PIXEL,  11'h7FF, 4'd15, 4'd15, 4'd15, 16'hFFFF, EXP_NONE},
        // windows that use the corner entries just written
        '{CMD_COMPUTE,     11'h000, 4'd0,  4'd0,  4'h0, 16'h0000, EXP_PREDICT},
        '{CMD_COMPUTE,     11'h000, 4'd10, 4'd10, 4'h0, 16'h0000, EXP_PREDICT},
        '{CMD_LOAD_PIXEL,  11'h000, 4'd2,  4'd2,  4'd3,  16'h0000, EXP_NONE},
        '{CMD_COMPUTE,     11'h000, 4'd2,  4'd2,  4'h0, 16'h0000, EXP_PREDICT},
        '{CMD_COMPUTE,     11'h000, 4'd11, 4'd11, 4'h0, 16'h0000, EXP_ERR_BEAT}
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // weight_index[10:0], row[14:11], col[18:15], channel[22:19], value[38:23], zero[39]
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    // command[1:0]
    logic [CMD_W-1:0]       s_axis_tuser  = CMD_LOAD_WEIGHT;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // out_channel[3:0], activation[18:4], zero[23:19]
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    // error[0]
    logic                   m_axis_tuser;

    // shadow copy of the three stores
    logic signed [15:0] wgt_mem  [N_WGT];
    logic signed [15:0] bias_mem [OUT_CH];
    logic signed [15:0] pix_mem  [N_PIX];

    act_beat_t acts_due [$];

    bit calm     = 1'b0;   // both sides stop idling while set
    bit hold_req = 1'b0;   // asks the receiver for its long hold-off
    bit hold_done = 1'b0;
    int hold_left = 0;

    int fail_cnt     = 0;
    int n_loads      = 0;
    int n_computes   = 0;
    int n_pos_errs   = 0;
    int n_beats_seen = 0;

    conv3x3_relu_layer_top #(
        .IN_SIZE      (MAP_SIZE),
        .IN_CHANNELS  (MAP_CH),
        .OUT_CHANNELS (OUT_CH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // updates the shadow stores and yields the activation beats a command causes
    function automatic void conv_relu_apply(input cmd_code_t cmd, input logic [10:0] widx,
                                            input logic [3:0] row, input logic [3:0] col,
                                            input logic [3:0] ch, input logic [15:0] val,
                                            ref act_beat_t beats [$]);
        int        r;
        int        c;
        int        prod;
        logic [15:0] acc;
        act_beat_t b;
        r = row;
        c = col;
        beats.delete();
        case (cmd)
            CMD_LOAD_WEIGHT:
                if (widx < N_WGT) wgt_mem[widx] = val;
            CMD_LOAD_BIAS:
                if (ch < OUT_CH) bias_mem[ch] = val;
            CMD_LOAD_PIXEL:
                if (r < MAP_SIZE && c < MAP_SIZE && ch < MAP_CH)
                    pix_mem[(r * MAP_SIZE + c) * MAP_CH + ch] = val;
            default:
            begin
                if (r > LAST_POS || c > LAST_POS)
                begin
                    beats.push_back(ERR_BEAT);
                end
                else
                begin
                    for (int oc = 0; oc < OUT_CH; oc++)
                    begin
                        acc = bias_mem[oc];
                        for (int kr = 0; kr < 3; kr++)
                            for (int kc = 0; kc < 3; kc++)
                                for (int ic = 0; ic < MAP_CH; ic++)
                                begin
                                    prod = pix_mem[((r + kr) * MAP_SIZE + c + kc) * MAP_CH + ic]
                                         * wgt_mem[((kr * 3 + kc) * MAP_CH + ic) * OUT_CH + oc];
                                    // arithmetic shift floors; the sum wraps at 16 bits
                                    acc = acc + 16'(prod >>> FRAC_BITS);
                                end
                        b.och  = OCH_W'(oc);
                        b.act  = acc[15] ? '0 : acc[14:0];
                        b.last = (oc == OUT_CH - 1);
                        b.err  = 1'b0;
                        beats.push_back(b);
                    end
                end
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_value(input bit wide);
        int roll;
        roll = $urandom_range(0, 9);
        if (wide && roll == 0) return 16'h7FFF;
        if (wide && roll == 1) return 16'h8000;
        if (wide && roll < 4) return 16'($urandom);
        // about +-2.0, keeps most sums away from wrap
        return 16'($urandom_range(0, 4095)) - 16'd2048;
    endfunction

    task automatic note_fail(input string msg);
        if (fail_cnt < REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // offers one beat on the slave side, waits for the handshake, then records what
    // the accepted command should produce
    task automatic send_beat(input cmd_code_t cmd, input logic [10:0] widx,
                             input logic [3:0] row, input logic [3:0] col,
                             input logic [3:0] ch, input logic [15:0] val,
                             input exp_src_t src);
        act_beat_t beats [$];
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, ch, col, row, widx};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        // accepted at this edge
        conv_relu_apply(cmd, widx, row, col, ch, val, beats);
        if (cmd == CMD_COMPUTE)
        begin
            n_computes++;
            if (beats.size() == 1) n_pos_errs++;
        end
        else
        begin
            n_loads++;
        end
        case (src)
            EXP_PREDICT:  foreach (beats[i]) acts_due.push_back(beats[i]);
            EXP_ERR_BEAT: acts_due.push_back(ERR_BEAT);
            default: ;
        endcase
    endtask

    // receiver: checks every accepted beat and drives tready, with one long hold-off
    always @(posedge clk)
    begin
        act_beat_t got;
        act_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_beats_seen++;
            got.och  = m_axis_tdata[OCH_W-1:0];
            got.act  = m_axis_tdata[OCH_W+ACT_W-1:OCH_W];
            got.last = m_axis_tlast;
            got.err  = m_axis_tuser;
            if (m_axis_tdata[M_TDATA_W-1:OCH_W+ACT_W] !== '0)
                note_fail($sformatf("pad bits not zero: tdata %h", m_axis_tdata));
            if (acts_due.size() == 0)
            begin
                note_fail($sformatf("beat with nothing pending: och %0d act %h last %b err %b",
                                    got.och, got.act, got.last, got.err));
            end
            else
            begin
                want = acts_due.pop_front();
                if (got.och !== want.och || got.act !== want.act ||
                    got.last !== want.last || got.err !== want.err)
                    note_fail($sformatf({"och %0d/%0d act %h/%h last %b/%b err %b/%b",
                                         " (expected/actual)"},
                                        want.och, got.och, want.act, got.act,
                                        want.last, got.last, want.err, got.err));
            end
        end
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        cmd_code_t   cmd;
        logic [10:0] widx;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [3:0]  ch;
        logic [15:0] val;
        int          roll;
        bit          force_compute;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store first so no compute ever reads an unwritten entry
        for (int i = 0; i < N_WGT; i++)
            send_beat(CMD_LOAD_WEIGHT, 11'(i), 4'($urandom), 4'($urandom), 4'($urandom),
                      pick_value(1'b0), EXP_NONE);
        for (int i = 0; i < OUT_CH; i++)
            send_beat(CMD_LOAD_BIAS, 11'($urandom), 4'($urandom), 4'($urandom), 4'(i),
                      pick_value(1'b0), EXP_NONE);
        for (int r = 0; r < MAP_SIZE; r++)
            for (int c = 0; c < MAP_SIZE; c++)
                for (int k = 0; k < MAP_CH; k++)
                    send_beat(CMD_LOAD_PIXEL, 11'($urandom), 4'(r), 4'(c), 4'(k),
                              pick_value(1'b0), EXP_NONE);

        foreach (dir_rows[k])
            send_beat(dir_rows[k].cmd, dir_rows[k].widx, dir_rows[k].row, dir_rows[k].col,
                      dir_rows[k].ch, dir_rows[k].val, dir_rows[k].src);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm <= (n >= 60 && n < 100);
            // receiver stalls while computes keep coming, so the block backs up
            if (n == 120) hold_req <= 1'b1;
            force_compute = (n >= 120 && n < 123);
            if (n == 150)
            begin
                // let the block drain completely before going on
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (acts_due.size() != 0) @(posedge clk);
            end

            // unused fields stay random so every bit toggles
            widx = 11'($urandom);
            row  = 4'($urandom);
            col  = 4'($urandom);
            ch   = 4'($urandom);
            val  = pick_value(1'b1);
            roll = $urandom_range(0, 99);
            if (force_compute || roll < 30)
            begin
                cmd = CMD_COMPUTE;
                if (force_compute || $urandom_range(0, 4) != 0)
                begin
                    row = 4'($urandom_range(0, LAST_POS));
                    col = 4'($urandom_range(0, LAST_POS));
                end
            end
            else if (roll < 55)
            begin
                cmd = CMD_LOAD_WEIGHT;
                if ($urandom_range(0, 9) != 0) widx = 11'($urandom_range(0, N_WGT - 1));
            end
            else if (roll < 65)
            begin
                cmd = CMD_LOAD_BIAS;
            end
            else if (roll < 92)
            begin
                cmd = CMD_LOAD_PIXEL;
                if ($urandom_range(0, 7) != 0)
                begin
                    row = 4'($urandom_range(0, MAP_SIZE - 1));
                    col = 4'($urandom_range(0, MAP_SIZE - 1));
                    ch  = 4'($urandom_range(0, MAP_CH - 1));
                end
            end
            else
            begin
                // noise: any command with fully random fields
                cmd = cmd_code_t'($urandom_range(0, 3));
            end
            send_beat(cmd, widx, row, col, ch, val, EXP_PREDICT);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (acts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d computes (%0d with a bad position)",
                 n_loads, n_computes, n_pos_errs);
        $display("checked %0d activation beats, %0d mismatches", n_beats_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d beats still pending", acts_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== conv3x3_relu_layer_top.f =====
sv/c3r_pkg.sv
sv/c3r_ctrl.sv
sv/c3r_dp.sv
sv/conv3x3_relu_layer_top.sv
tb/sv/conv3x3_relu_layer_top_tb.sv
